// File: design/spid_pkg.sv
package spid_pkg;

  localparam int ANGLE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 17;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam int ACCUM_WIDTH_DEF = 32;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEGRAL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_UPPER   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_LOWER   = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_PROP_RST     = 16'd13107;
  localparam logic [GAIN_W-1:0]  GAIN_INTEGRAL_RST = 16'd197;
  localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST    = 16'd655;
  localparam logic [ANGLE_W-1:0] DRIVE_UPPER_RST   = 16'd45824;
  localparam logic [ANGLE_W-1:0] DRIVE_LOWER_RST   = 16'd256;

  typedef struct packed {
    logic [ANGLE_W-1:0] measured_angle;
    logic [ANGLE_W-1:0] target_angle;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] drive_angle;
    logic               was_clamped;
  } out_item_t;

endpackage

// File: design/servo_position_pid_unit.sv
// Positional PID controller for a servo angle. Each input item carries a
// measured and a target angle (unsigned, 1/256 degree); each yields exactly
// one result item with the clamped drive angle and a clamp flag. The block
// takes one item per cycle unless the output stalls; the error, saturating
// integral sum and difference are formed as the item enters, the three gain
// products are registered in the second stage, and the rounded sum and clamp
// fill the output register. Gains and limits are written over the APB port
// at byte address 4*index; the user must write them only while the block is
// idle, which the block itself does not enforce.
module servo_position_pid_unit #(
  parameter int ACCUM_WIDTH = spid_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  spid_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output spid_pkg::out_item_t          out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spid_pkg::ADDR_W-1:0]  paddr,
  input  logic [spid_pkg::DATA_W-1:0]  pwdata,
  output logic [spid_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int AW   = ACCUM_WIDTH;
  localparam int EW   = spid_pkg::ERR_W;
  localparam int GW   = spid_pkg::GAIN_W;
  localparam int NW   = spid_pkg::ANGLE_W;
  localparam int IPW  = AW + GW + 1;
  localparam int LIMW = 52;
  localparam int PW   = (IPW > LIMW) ? IPW : LIMW;
  localparam int TW   = LIMW + 2;
  localparam int RW   = TW - 16;
  localparam int DW   = RW + 1;

  localparam logic signed [PW-1:0] ILIM_POS = {{(PW-51){1'b0}}, 1'b1, 50'b0};
  localparam logic signed [PW-1:0] ILIM_NEG = -ILIM_POS;
  localparam logic signed [AW-1:0] ACC_MAX  = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN  = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [TW-1:0] HALF_LSB = TW'(32768);

  logic [GW-1:0] gain_prop;
  logic [GW-1:0] gain_integral;
  logic [GW-1:0] gain_deriv;
  logic [NW-1:0] drive_upper;
  logic [NW-1:0] drive_lower;

  logic                         cfg_we;
  logic [spid_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[spid_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= spid_pkg::GAIN_PROP_RST;
      gain_integral <= spid_pkg::GAIN_INTEGRAL_RST;
      gain_deriv    <= spid_pkg::GAIN_DERIV_RST;
      drive_upper   <= spid_pkg::DRIVE_UPPER_RST;
      drive_lower   <= spid_pkg::DRIVE_LOWER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        spid_pkg::REG_GAIN_PROP:     gain_prop     <= pwdata[GW-1:0];
        spid_pkg::REG_GAIN_INTEGRAL: gain_integral <= pwdata[GW-1:0];
        spid_pkg::REG_GAIN_DERIV:    gain_deriv    <= pwdata[GW-1:0];
        spid_pkg::REG_DRIVE_UPPER:   drive_upper   <= pwdata[NW-1:0];
        spid_pkg::REG_DRIVE_LOWER:   drive_lower   <= pwdata[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      spid_pkg::REG_GAIN_PROP:     prdata = {{(spid_pkg::DATA_W-GW){1'b0}}, gain_prop};
      spid_pkg::REG_GAIN_INTEGRAL: prdata = {{(spid_pkg::DATA_W-GW){1'b0}}, gain_integral};
      spid_pkg::REG_GAIN_DERIV:    prdata = {{(spid_pkg::DATA_W-GW){1'b0}}, gain_deriv};
      spid_pkg::REG_DRIVE_UPPER:   prdata = {{(spid_pkg::DATA_W-NW){1'b0}}, drive_upper};
      spid_pkg::REG_DRIVE_LOWER:   prdata = {{(spid_pkg::DATA_W-NW){1'b0}}, drive_lower};
      default:                     prdata = '0;
    endcase
  end

  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic ready1;
  logic ready2;
  logic ready3;
  logic accept;

  assign ready3   = !s3_valid || !out_stall;
  assign ready2   = !s2_valid || ready3;
  assign ready1   = !s1_valid || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;

  logic signed [EW-1:0] previous_error;
  logic signed [AW-1:0] error_accumulator;
  logic signed [EW-1:0] err;
  logic signed [EW:0]   diff;
  logic signed [AW:0]   acc_sum;
  logic signed [AW-1:0] error_accumulator_next;

  assign err     = $signed({1'b0, in_item.target_angle}) - $signed({1'b0, in_item.measured_angle});
  assign diff    = $signed({err[EW-1], err}) - $signed({previous_error[EW-1], previous_error});
  assign acc_sum = $signed({{(AW-EW+1){err[EW-1]}}, err})
                 + $signed({error_accumulator[AW-1], error_accumulator});

  always_comb begin
    if (acc_sum[AW] != acc_sum[AW-1]) begin
      error_accumulator_next = acc_sum[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      error_accumulator_next = acc_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error    <= '0;
      error_accumulator <= '0;
    end else if (accept) begin
      previous_error    <= err;
      error_accumulator <= error_accumulator_next;
    end
  end

  logic [NW-1:0]        s1_meas;
  logic signed [EW-1:0] s1_err;
  logic signed [EW:0]   s1_diff;
  logic signed [AW-1:0] s1_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meas <= in_item.measured_angle;
      s1_err  <= err;
      s1_diff <= diff;
      s1_acc  <= error_accumulator_next;
    end
  end

  logic signed [2*EW-1:0] prod_p;
  logic signed [2*EW:0]   prod_d;
  logic signed [IPW-1:0]  prod_i;
  logic signed [PW-1:0]   prod_i_x;
  logic signed [LIMW-1:0] prod_i_c;

  assign prod_p   = $signed({1'b0, gain_prop}) * s1_err;
  assign prod_d   = $signed({1'b0, gain_deriv}) * s1_diff;
  assign prod_i   = $signed({1'b0, gain_integral}) * s1_acc;
  assign prod_i_x = PW'(prod_i);

  always_comb begin
    if (prod_i_x > ILIM_POS) begin
      prod_i_c = ILIM_POS[LIMW-1:0];
    end else if (prod_i_x < ILIM_NEG) begin
      prod_i_c = ILIM_NEG[LIMW-1:0];
    end else begin
      prod_i_c = prod_i_x[LIMW-1:0];
    end
  end

  logic [NW-1:0]          s2_meas;
  logic signed [2*EW-1:0] s2_p;
  logic signed [2*EW:0]   s2_d;
  logic signed [LIMW-1:0] s2_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      s2_meas <= s1_meas;
      s2_p    <= prod_p;
      s2_d    <= prod_d;
      s2_i    <= prod_i_c;
    end
  end

  logic signed [TW-1:0] total;
  logic signed [TW-1:0] total_r;
  logic signed [RW-1:0] rnd;
  logic signed [DW-1:0] drive;
  logic signed [DW-1:0] upper_x;
  logic signed [DW-1:0] lower_x;
  spid_pkg::out_item_t  result;

  assign total   = $signed({{(TW-LIMW){s2_i[LIMW-1]}}, s2_i})
                 + $signed({{(TW-2*EW){s2_p[2*EW-1]}}, s2_p})
                 + $signed({{(TW-2*EW-1){s2_d[2*EW]}}, s2_d});
  assign total_r = total + HALF_LSB;
  assign rnd     = total_r[TW-1:16];
  assign drive   = $signed({{(DW-NW){1'b0}}, s2_meas}) + $signed({rnd[RW-1], rnd});
  assign upper_x = $signed({{(DW-NW){1'b0}}, drive_upper});
  assign lower_x = $signed({{(DW-NW){1'b0}}, drive_lower});

  always_comb begin
    if (drive > upper_x) begin
      result.drive_angle = drive_upper;
      result.was_clamped = 1'b1;
    end else if (drive < lower_x) begin
      result.drive_angle = drive_lower;
      result.was_clamped = 1'b1;
    end else begin
      result.drive_angle = drive[NW-1:0];
      result.was_clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_valid) begin
      out_item <= result;
    end
  end

  assign out_valid = s3_valid;

endmodule

// File: design/spid_checker.sv
module spid_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input spid_pkg::out_item_t          out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side drains");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result item missing three cycles after accept");

endmodule

bind servo_position_pid_unit spid_checker u_spid_checker (.*);
